// ----- hdl/platform_interrupt_controller_core_defines.svh -----
// assertion macros for the interrupt controller core
// the clk and rst_n names of the including module are used
// active only in simulation, empty bodies for synthesis
`ifndef PLATFORM_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH
`define PLATFORM_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PIC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PIC_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PIC_ASSERT(name, prop, msg)
`define PIC_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ----- hdl/pic_pkg.sv -----
// shared types and constants of the interrupt controller core
// no dependencies
`default_nettype none

package pic_pkg;

  localparam int WORD_BITS = 32;

  typedef enum logic [2:0] {
    MODE_RAISE     = 3'd0,
    MODE_WR_PRIO   = 3'd1,
    MODE_WR_ENABLE = 3'd2,
    MODE_WR_THRESH = 3'd3,
    MODE_CLAIM     = 3'd4,
    MODE_RD_PEND   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  source;
    logic        context_req;
    logic [2:0]  priority_value;
    logic        word_index;
    logic [31:0] word_value;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  claimed_id;
    logic [31:0] read_data;
  } out_item_t;

  // sequencer controls for the shared compare unit
  typedef struct packed {
    logic init;
    logic eval;
  } scan_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/pic_prio_mem.sv -----
// source priority memory with per-entry valid bits, registered read
// no package dependencies
`default_nettype none

module pic_prio_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 3
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0] rd_mem_r;
  logic          rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_mem_r <= mem[raddr];
      rd_vld_r <= vld_r[raddr];
    end
  end

  // never-written entries read as zero priority
  assign rdata = rd_vld_r ? rd_mem_r : '0;

endmodule

`default_nettype wire

// ----- hdl/pic_scan_unit.sv -----
// shared compare unit: keeps the best candidate seen during a claim scan
// uses pic_pkg::scan_ctrl_t
`default_nettype none

module pic_scan_unit #(
  parameter int IW = 6,
  parameter int PW = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pic_pkg::scan_ctrl_t ctrl,
  input  wire logic               cand_qual,
  input  wire logic [IW-1:0]      cand_id,
  input  wire logic [PW-1:0]      cand_prio,
  input  wire logic [PW-1:0]      threshold,
  output logic      [IW-1:0]      best_id
);

  logic [IW-1:0] best_id_r, best_id_nxt;
  logic [PW-1:0] best_prio_r, best_prio_nxt;

  always_comb begin
    best_id_nxt   = best_id_r;
    best_prio_nxt = best_prio_r;
    if (ctrl.init) begin
      best_id_nxt   = '0;
      best_prio_nxt = '0;
    end else if (ctrl.eval && cand_qual && (cand_prio > threshold) &&
                 (cand_prio > best_prio_r)) begin
      // strict compare keeps the lowest id on ties
      best_id_nxt   = cand_id;
      best_prio_nxt = cand_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_id_r   <= '0;
      best_prio_r <= '0;
    end else begin
      best_id_r   <= best_id_nxt;
      best_prio_r <= best_prio_nxt;
    end
  end

  assign best_id = best_id_r;

endmodule

`default_nettype wire

// ----- hdl/platform_interrupt_controller_core.sv -----
// platform-level interrupt controller core: sequencer, pending and enable state
// uses pic_pkg, pic_prio_mem, pic_scan_unit and the assertion macro header
//
// A transaction is accepted when start is high and busy is low. Raise, priority
// write, enable write, threshold write and pending read finish at once: the
// result strobes out_valid in the next cycle and busy stays low, so one such
// transaction can be taken every cycle. A claim for a present context walks
// the sources one per cycle through the single compare unit, reading one
// priority memory entry a cycle: busy is high while the scan runs and the
// result shows in the cycle busy drops, so no new transaction is taken until
// the claim is done. The result is shown for exactly one cycle; the receiver
// must take it then. Every result carries claimed_id (zero unless a claim
// found a winner) and read_data (zero unless a pending read).
`default_nettype none

`include "platform_interrupt_controller_core_defines.svh"

module platform_interrupt_controller_core #(
  parameter int NUM_SOURCES   = 64,
  parameter int NUM_CONTEXTS  = 2,
  parameter int PRIORITY_BITS = 3
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire pic_pkg::in_item_t   in_data,
  output logic                     out_valid,
  output pic_pkg::out_item_t       out_data
);

  localparam int IW    = $clog2(NUM_SOURCES);
  localparam int WORDS = (NUM_SOURCES + pic_pkg::WORD_BITS - 1) / pic_pkg::WORD_BITS;
  localparam int PAD   = WORDS * pic_pkg::WORD_BITS;
  localparam int PIW   = $clog2(PAD);
  localparam int CW    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int PW    = PRIORITY_BITS;

  // control state
  pic_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [PAD-1:0]  pend_r, pend_nxt;
  logic [PAD-1:0]  en_r [NUM_CONTEXTS];
  logic [PAD-1:0]  en_nxt [NUM_CONTEXTS];
  logic [PW-1:0]   thr_r [NUM_CONTEXTS];
  logic [PW-1:0]   thr_nxt [NUM_CONTEXTS];

  // payload state
  logic [CW-1:0]       ctx_r, ctx_nxt;
  logic                stg_vld_r, stg_vld_nxt;
  logic                stg_qual_r, stg_qual_nxt;
  logic [IW-1:0]       stg_id_r, stg_id_nxt;
  pic_pkg::out_item_t  out_data_r, out_data_nxt;

  // decoded transaction fields
  logic          accept;
  logic          src_ok, ctx_ok, widx_ok;
  logic [IW+5:0] src_ax;
  logic [PIW+5:0] src_px;
  logic [IW-1:0] src_addr;
  logic [PIW-1:0] src_bit;
  logic [CW:0]   ctx_x;
  logic [CW-1:0] ctx_i;
  logic [PW+2:0] pval_x;
  logic [PW-1:0] pval;
  logic [31:0]   rd_word;

  // shared unit and memory hookup
  pic_pkg::scan_ctrl_t scan_ctrl;
  logic          pm_we, pm_re;
  logic [PW-1:0] pm_rdata;
  logic [IW-1:0] best_id;
  logic [IW+5:0] best_x;

  assign accept   = start && !busy;
  assign src_ok   = (in_data.source != 6'd0) && (32'(in_data.source) < NUM_SOURCES);
  assign ctx_ok   = 32'(in_data.context_req) < NUM_CONTEXTS;
  assign widx_ok  = 32'(in_data.word_index) < WORDS;
  assign src_ax   = {IW'(0), in_data.source};
  assign src_addr = src_ax[IW-1:0];
  assign src_px   = {PIW'(0), in_data.source};
  assign src_bit  = src_px[PIW-1:0];
  assign ctx_x    = {CW'(0), in_data.context_req};
  assign ctx_i    = ctx_x[CW-1:0];
  // priority and threshold keep their low PRIORITY_BITS bits
  assign pval_x   = {PW'(0), in_data.priority_value};
  assign pval     = pval_x[PW-1:0];
  assign best_x   = {6'd0, best_id};

  // pending word for a read
  always_comb begin
    rd_word = '0;
    for (int w = 0; w < WORDS; w++) begin
      if (widx_ok && (32'(in_data.word_index) == w)) begin
        rd_word = pend_r[w*pic_pkg::WORD_BITS +: pic_pkg::WORD_BITS];
      end
    end
  end

  // sequencer: next state and outputs
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ctx_nxt       = ctx_r;
    pend_nxt      = pend_r;
    en_nxt        = en_r;
    thr_nxt       = thr_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    stg_vld_nxt   = 1'b0;
    stg_qual_nxt  = 1'b0;
    stg_id_nxt    = cnt_r;
    pm_we         = 1'b0;
    pm_re         = 1'b0;
    scan_ctrl     = '0;
    scan_ctrl.eval = stg_vld_r;

    unique case (state_r)
      pic_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          unique case (pic_pkg::mode_t'(in_data.mode))
            pic_pkg::MODE_RAISE: begin
              if (src_ok) begin
                pend_nxt[src_bit] = 1'b1;
              end
            end
            pic_pkg::MODE_WR_PRIO: begin
              pm_we = src_ok;
            end
            pic_pkg::MODE_WR_ENABLE: begin
              for (int c = 0; c < NUM_CONTEXTS; c++) begin
                for (int w = 0; w < WORDS; w++) begin
                  if (ctx_ok && widx_ok && (32'(ctx_i) == c) &&
                      (32'(in_data.word_index) == w)) begin
                    en_nxt[c][w*pic_pkg::WORD_BITS +: pic_pkg::WORD_BITS] =
                      in_data.word_value;
                  end
                end
              end
            end
            pic_pkg::MODE_WR_THRESH: begin
              if (ctx_ok) begin
                thr_nxt[ctx_i] = pval;
              end
            end
            pic_pkg::MODE_CLAIM: begin
              // a claim for a missing context answers zero at once
              if (ctx_ok) begin
                out_valid_nxt  = 1'b0;
                state_nxt      = pic_pkg::ST_SCAN;
                cnt_nxt        = IW'(1);
                ctx_nxt        = ctx_i;
                scan_ctrl.init = 1'b1;
              end
            end
            pic_pkg::MODE_RD_PEND: begin
              out_data_nxt.read_data = rd_word;
            end
            default: begin
            end
          endcase
        end
      end
      pic_pkg::ST_SCAN: begin
        // issue one source per cycle, its priority is registered and arrives in the next cycle
        pm_re        = 1'b1;
        stg_vld_nxt  = 1'b1;
        stg_qual_nxt = pend_r[PIW'(cnt_r)] & en_r[ctx_r][PIW'(cnt_r)];
        if (cnt_r == IW'(NUM_SOURCES - 1)) begin
          state_nxt = pic_pkg::ST_LAST;
        end else begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      pic_pkg::ST_LAST: begin
        // last candidate is evaluated in this cycle
        state_nxt = pic_pkg::ST_EMIT;
      end
      pic_pkg::ST_EMIT: begin
        if (best_id != '0) begin
          pend_nxt[PIW'(best_id)] = 1'b0;
        end
        out_valid_nxt           = 1'b1;
        out_data_nxt.claimed_id = best_x[5:0];
        state_nxt               = pic_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pic_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pic_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= '0;
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        en_r[c]  <= '0;
        thr_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      en_r        <= en_nxt;
      thr_r       <= thr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctx_r      <= ctx_nxt;
    stg_vld_r  <= stg_vld_nxt;
    stg_qual_r <= stg_qual_nxt;
    stg_id_r   <= stg_id_nxt;
    out_data_r <= out_data_nxt;
  end

  pic_prio_mem #(
    .DEPTH (NUM_SOURCES),
    .AW    (IW),
    .DW    (PW)
  ) u_prio_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (pm_we),
    .waddr (src_addr),
    .wdata (pval),
    .re    (pm_re),
    .raddr (cnt_r),
    .rdata (pm_rdata)
  );

  pic_scan_unit #(
    .IW (IW),
    .PW (PW)
  ) u_scan_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (scan_ctrl),
    .cand_qual (stg_qual_r),
    .cand_id   (stg_id_r),
    .cand_prio (pm_rdata),
    .threshold (thr_r[ctx_r]),
    .best_id   (best_id)
  );

  assign busy      = (state_r != pic_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // emit state always produces exactly one result strobe
  `PIC_ASSERT(a_emit_strobes, (state_r == pic_pkg::ST_EMIT) |=> (out_valid && !busy), "claim result missing after emit")
  // no result may appear while a scan is running
  `PIC_ASSERT_NEVER(a_quiet_scan, (state_r == pic_pkg::ST_SCAN) && out_valid, "result strobe during claim scan")
  // reserved source zero is never pending
  `PIC_ASSERT_NEVER(a_src0_idle, pend_r[0], "source zero marked pending")
  // a claim for a present context holds off further transactions
  `PIC_ASSERT(a_claim_busy, (accept && (in_data.mode == pic_pkg::MODE_CLAIM) && ctx_ok) |=> (busy && !out_valid), "claim did not start a scan")

endmodule

`default_nettype wire
